// File: design/uaehm_pkg.sv
// Package: event codes, register indexes, field widths and reset values for the UPS alert monitor
`default_nettype none
package uaehm_pkg;

  // Field widths
  localparam int unsigned VOLT_W     = 14;
  localparam int unsigned LOAD_W     = 11;
  localparam int unsigned CHARGE_W   = 10;
  localparam int unsigned XFER_W     = 10;
  localparam int unsigned TENTHS_W   = 10;
  localparam int unsigned LOAD_LIM_W = 8;
  localparam int unsigned BATT_LIM_W = 7;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned MASK_W     = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register reset values
  localparam logic [XFER_W-1:0]     XFER_HIGH_RST  = '0;
  localparam logic [XFER_W-1:0]     XFER_LOW_RST   = '0;
  localparam logic [TENTHS_W-1:0]   WARN_OFS_RST   = TENTHS_W'(50);
  localparam logic [TENTHS_W-1:0]   DEADBAND_RST   = TENTHS_W'(10);
  localparam logic [LOAD_LIM_W-1:0] LOAD_LIM_RST   = LOAD_LIM_W'(80);
  localparam logic [BATT_LIM_W-1:0] BATT_LIM_RST   = BATT_LIM_W'(20);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XFER_HIGH = 3'd0,
    REG_XFER_LOW  = 3'd1,
    REG_WARN_OFS  = 3'd2,
    REG_DEADBAND  = 3'd3,
    REG_LOAD_LIM  = 3'd4,
    REG_BATT_LIM  = 3'd5
  } cfg_reg_t;

  // Per-alert event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_RAISED  = 2'd1,
    EV_CLEARED = 2'd2
  } event_t;

  // Event from the stored level and the newly evaluated one
  function automatic event_t level_event(input logic level, input logic now);
    event_t ev;
    ev = EV_NONE;
    if (now && !level) begin
      ev = EV_RAISED;
    end else if (!now && level) begin
      ev = EV_CLEARED;
    end
    return ev;
  endfunction

endpackage
`default_nettype wire

// File: design/uaehm_in_if.sv
// Interface: reading channel (valid, ready and one power-supply reading)
`default_nettype none
interface uaehm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              overload_flag;
  logic                              fault_flag;
  logic                              online_flag;
  logic                              replace_flag;
  logic [uaehm_pkg::VOLT_W-1:0]      voltage_tenths;
  logic [uaehm_pkg::LOAD_W-1:0]      load_tenths;
  logic [uaehm_pkg::CHARGE_W-1:0]    charge_tenths;

  modport source (
    output valid, overload_flag, fault_flag, online_flag, replace_flag,
           voltage_tenths, load_tenths, charge_tenths,
    input  ready
  );
  modport sink (
    input  valid, overload_flag, fault_flag, online_flag, replace_flag,
           voltage_tenths, load_tenths, charge_tenths,
    output ready
  );
endinterface
`default_nettype wire

// File: design/uaehm_out_if.sv
// Interface: result channel (valid, ready and the alert events of one reading)
`default_nettype none
interface uaehm_out_if;
  logic                            valid;
  logic                            ready;
  logic [uaehm_pkg::EVENT_W-1:0]   overload_event;
  logic [uaehm_pkg::EVENT_W-1:0]   fault_event;
  logic [uaehm_pkg::EVENT_W-1:0]   replace_event;
  logic [uaehm_pkg::EVENT_W-1:0]   volt_high_event;
  logic [uaehm_pkg::EVENT_W-1:0]   volt_low_event;
  logic [uaehm_pkg::EVENT_W-1:0]   load_event;
  logic [uaehm_pkg::EVENT_W-1:0]   battery_low_event;
  logic [uaehm_pkg::MASK_W-1:0]    suppress_mask;

  modport source (
    output valid, overload_event, fault_event, replace_event, volt_high_event,
           volt_low_event, load_event, battery_low_event, suppress_mask,
    input  ready
  );
  modport sink (
    input  valid, overload_event, fault_event, replace_event, volt_high_event,
           volt_low_event, load_event, battery_low_event, suppress_mask,
    output ready
  );
endinterface
`default_nettype wire

// File: design/ups_alert_edge_hysteresis_monitor.sv
// Top level: UPS alert monitor with edge detection and voltage hysteresis
// A reading enters the input register at the edge that accepts it and is then
// evaluated into the result register, from which its result is offered.
// Throughput: one reading per cycle; the two-stage valid/ready pipeline keeps
// accepting while a result waits, and stalls only when both stages are full.
// Reset (synchronous, rst_n low): pipeline empty, all alert levels and the
// charge history cleared, configuration registers at their default values.
`default_nettype none
module ups_alert_edge_hysteresis_monitor (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  uaehm_in_if.sink                                  in_bus,
  uaehm_out_if.source                               out_bus,
  input  wire logic                                 cfg_we,
  input  wire logic [uaehm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [uaehm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned VW = uaehm_pkg::VOLT_W;
  localparam int unsigned LW = uaehm_pkg::LOAD_W;
  localparam int unsigned CW = uaehm_pkg::CHARGE_W;
  localparam int unsigned XW = uaehm_pkg::XFER_W;
  localparam int unsigned TW = uaehm_pkg::TENTHS_W;
  localparam int unsigned SW = VW + 2;  // signed threshold width

  // Configuration registers
  logic [XW-1:0]                        xfer_high_r;
  logic [XW-1:0]                        xfer_low_r;
  logic [TW-1:0]                        warn_ofs_r;
  logic [TW-1:0]                        deadband_r;
  logic [uaehm_pkg::LOAD_LIM_W-1:0]     load_lim_r;
  logic [uaehm_pkg::BATT_LIM_W-1:0]     batt_lim_r;

  // Input stage
  logic          s1_valid_r;
  logic          ovl_r, flt_r, onl_r, rep_r;
  logic [VW-1:0] volt_r;
  logic [LW-1:0] load_r;
  logic [CW-1:0] charge_r;

  // Alert state
  logic          ovl_lvl_r, flt_lvl_r, rep_lvl_r, vh_lvl_r, vl_lvl_r, load_lvl_r;
  logic          batt_lvl_r;
  logic [CW-1:0] last_charge_r;
  logic          last_charge_valid_r;

  // Result stage
  logic          out_valid_r;
  uaehm_pkg::event_t ovl_ev_r, flt_ev_r, rep_ev_r, vh_ev_r, vl_ev_r, load_ev_r, batt_ev_r;
  logic [uaehm_pkg::MASK_W-1:0] mask_r;

  // Handshake control
  logic out_adv, s1_adv, in_acc;

  assign out_adv      = !out_valid_r || out_bus.ready;
  assign s1_adv       = s1_valid_r && out_adv;
  assign in_bus.ready = !s1_valid_r || out_adv;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Evaluation
  logic [VW-1:0]          xh_x10, xl_x10;
  logic signed [SW-1:0]   volt_s, vh_enter, vh_clear, vl_enter, vl_clear;
  logic                   vh_now, vl_now, vh_lvl_nxt, vl_lvl_nxt;
  logic [LW:0]            load_lim_x10;
  logic [CW:0]            batt_lim_x10;
  logic                   below, rising, batt_enter, batt_recov;
  logic                   batt_lvl_nxt;
  uaehm_pkg::event_t      ovl_ev, flt_ev, rep_ev, vh_ev, vl_ev, load_ev, batt_ev;
  logic [uaehm_pkg::MASK_W-1:0] mask;

  always_comb begin
    // Scale transfer volts to tenths: x*8 + x*2
    xh_x10   = {1'b0, xfer_high_r, 3'b000} + {3'b000, xfer_high_r, 1'b0};
    xl_x10   = {1'b0, xfer_low_r, 3'b000} + {3'b000, xfer_low_r, 1'b0};
    volt_s   = $signed({2'b00, volt_r});
    vh_enter = $signed({2'b00, xh_x10}) - $signed({(SW-TW)'(0), warn_ofs_r});
    vh_clear = vh_enter - $signed({(SW-TW)'(0), deadband_r});
    vl_enter = $signed({2'b00, xl_x10}) + $signed({(SW-TW)'(0), warn_ofs_r});
    vl_clear = vl_enter + $signed({(SW-TW)'(0), deadband_r});

    // Voltage alerts with hysteresis; a zero transfer point holds the level
    vh_now = vh_lvl_r ? (volt_s > vh_clear) : (volt_s > vh_enter);
    vl_now = vl_lvl_r ? (volt_s < vl_clear) : (volt_s < vl_enter);
    vh_lvl_nxt = (xfer_high_r != '0) ? vh_now : vh_lvl_r;
    vl_lvl_nxt = (xfer_low_r != '0) ? vl_now : vl_lvl_r;
    vh_ev = uaehm_pkg::level_event(vh_lvl_r, vh_lvl_nxt);
    vl_ev = uaehm_pkg::level_event(vl_lvl_r, vl_lvl_nxt);

    // Plain flag edges
    ovl_ev = uaehm_pkg::level_event(ovl_lvl_r, ovl_r);
    flt_ev = uaehm_pkg::level_event(flt_lvl_r, flt_r);
    rep_ev = uaehm_pkg::level_event(rep_lvl_r, rep_r);
    mask   = {flt_lvl_r != flt_r, ovl_lvl_r != ovl_r};

    // Load high
    load_lim_x10 = {1'b0, load_lim_r, 3'b000} + {3'b000, load_lim_r, 1'b0};
    load_ev      = uaehm_pkg::level_event(load_lvl_r, {1'b0, load_r} > load_lim_x10);

    // Battery low: gated by line power and a charge that is not rising
    batt_lim_x10 = {1'b0, batt_lim_r, 3'b000} + {3'b000, batt_lim_r, 1'b0};
    below        = {1'b0, charge_r} < batt_lim_x10;
    rising       = !last_charge_valid_r || (charge_r > last_charge_r);
    batt_enter   = below && onl_r && !rising;
    batt_recov   = batt_lvl_r && (!below || !onl_r || rising);
    batt_ev      = uaehm_pkg::EV_NONE;
    batt_lvl_nxt = batt_lvl_r;
    if (batt_enter && !batt_lvl_r) begin
      batt_ev      = uaehm_pkg::EV_RAISED;
      batt_lvl_nxt = 1'b1;
    end else if (batt_recov) begin
      batt_ev      = uaehm_pkg::EV_CLEARED;
      batt_lvl_nxt = 1'b0;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfer_high_r <= uaehm_pkg::XFER_HIGH_RST;
      xfer_low_r  <= uaehm_pkg::XFER_LOW_RST;
      warn_ofs_r  <= uaehm_pkg::WARN_OFS_RST;
      deadband_r  <= uaehm_pkg::DEADBAND_RST;
      load_lim_r  <= uaehm_pkg::LOAD_LIM_RST;
      batt_lim_r  <= uaehm_pkg::BATT_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uaehm_pkg::REG_XFER_HIGH: xfer_high_r <= cfg_wdata[XW-1:0];
        uaehm_pkg::REG_XFER_LOW:  xfer_low_r  <= cfg_wdata[XW-1:0];
        uaehm_pkg::REG_WARN_OFS:  warn_ofs_r  <= cfg_wdata[TW-1:0];
        uaehm_pkg::REG_DEADBAND:  deadband_r  <= cfg_wdata[TW-1:0];
        uaehm_pkg::REG_LOAD_LIM:  load_lim_r  <= cfg_wdata[uaehm_pkg::LOAD_LIM_W-1:0];
        uaehm_pkg::REG_BATT_LIM:  batt_lim_r  <= cfg_wdata[uaehm_pkg::BATT_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request into the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ovl_r    <= in_bus.overload_flag;
      flt_r    <= in_bus.fault_flag;
      onl_r    <= in_bus.online_flag;
      rep_r    <= in_bus.replace_flag;
      volt_r   <= in_bus.voltage_tenths;
      load_r   <= in_bus.load_tenths;
      charge_r <= in_bus.charge_tenths;
    end
  end

  // Advance the alert state as each reading is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_lvl_r           <= 1'b0;
      flt_lvl_r           <= 1'b0;
      rep_lvl_r           <= 1'b0;
      vh_lvl_r            <= 1'b0;
      vl_lvl_r            <= 1'b0;
      load_lvl_r          <= 1'b0;
      batt_lvl_r          <= 1'b0;
      last_charge_r       <= '0;
      last_charge_valid_r <= 1'b0;
    end else if (s1_adv) begin
      ovl_lvl_r           <= ovl_r;
      flt_lvl_r           <= flt_r;
      rep_lvl_r           <= rep_r;
      vh_lvl_r            <= vh_lvl_nxt;
      vl_lvl_r            <= vl_lvl_nxt;
      load_lvl_r          <= {1'b0, load_r} > load_lim_x10;
      batt_lvl_r          <= batt_lvl_nxt;
      last_charge_r       <= charge_r;
      last_charge_valid_r <= 1'b1;
    end
  end

  // Result register; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ovl_ev_r  <= ovl_ev;
      flt_ev_r  <= flt_ev;
      rep_ev_r  <= rep_ev;
      vh_ev_r   <= vh_ev;
      vl_ev_r   <= vl_ev;
      load_ev_r <= load_ev;
      batt_ev_r <= batt_ev;
      mask_r    <= mask;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.overload_event    = ovl_ev_r;
  assign out_bus.fault_event       = flt_ev_r;
  assign out_bus.replace_event     = rep_ev_r;
  assign out_bus.volt_high_event   = vh_ev_r;
  assign out_bus.volt_low_event    = vl_ev_r;
  assign out_bus.load_event        = load_ev_r;
  assign out_bus.battery_low_event = batt_ev_r;
  assign out_bus.suppress_mask     = mask_r;

endmodule
`default_nettype wire
